>>> design/ubxfr_pkg.sv
// ubxfr_pkg: shared types, constants and codes for the frame receiver.
// No dependencies; imported by every module of the block.
package ubxfr_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 32;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned CHG_W = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 224;

  localparam logic [7:0] SYNC_FIRST = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [7:0] RST_CLASS = 8'd1;
  localparam logic [7:0] RST_ID = 8'd6;
  localparam logic [15:0] RST_LENGTH = 16'd52;

  localparam logic [CFG_IDX_W-1:0] REG_CLASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } ubxfr_phase_e;

  typedef struct packed {
    logic       sink_ready;
    logic       noise;
    logic       overrun;
    logic       framing;
    logic       parity;
    logic [7:0] rx_byte;
  } ubxfr_item_t;

  typedef struct packed {
    logic             bump_noise;
    logic             bump_overrun;
    logic             bump_framing;
    logic             bump_parity;
    logic             bump_good;
    logic [CHG_W-1:0] charge;
  } ubxfr_evt_t;

  typedef struct packed {
    logic        frame_bad;
    logic        frame_good;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
  } ubxfr_res_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] noise;
    logic [TOTAL_W-1:0] overrun;
    logic [TOTAL_W-1:0] framing;
    logic [TOTAL_W-1:0] parity;
    logic [TOTAL_W-1:0] good;
    logic [TOTAL_W-1:0] dropped;
  } ubxfr_totals_t;

endpackage

>>> design/ubxfr_parser.sv
// ubxfr_parser: sync hunt, header match, payload indexing and checksum check.
// Depends on ubxfr_pkg. Emits per-byte result fields and counter events.
module ubxfr_parser import ubxfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  ubxfr_item_t item_i,
  input  logic [7:0]  exp_class_i,
  input  logic [7:0]  exp_id_i,
  input  logic [15:0] exp_length_i,
  output ubxfr_res_t  res_o,
  output ubxfr_evt_t  evt_o
);

  ubxfr_phase_e phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  class_q, class_d;
  logic [15:0] dlen_q, dlen_d;
  logic [15:0] left_q, left_d;

  logic [7:0]  b;
  logic [7:0]  sa_abs;
  logic [7:0]  sb_abs;
  logic [15:0] got;
  logic [15:0] len_full;

  assign b        = item_i.rx_byte;
  assign sa_abs   = sum_a_q + b;
  assign sb_abs   = sum_b_q + sa_abs;
  assign got      = dlen_q - left_q;
  assign len_full = {b, dlen_q[7:0]};

  always_comb begin
    phase_d = phase_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    class_d = class_q;
    dlen_d  = dlen_q;
    left_d  = left_q;
    res_o   = '0;
    evt_o   = '0;
    evt_o.bump_parity  = item_i.parity;
    evt_o.bump_framing = item_i.framing;
    if (item_i.overrun) begin
      evt_o.bump_overrun = 1'b1;
      phase_d = PH_HUNT1;
      unique case (phase_q)
        PH_HUNT1:   evt_o.charge = CHG_W'(1);
        PH_HUNT2:   evt_o.charge = CHG_W'(2);
        PH_CLASS:   evt_o.charge = CHG_W'(3);
        PH_ID:      evt_o.charge = CHG_W'(4);
        PH_LEN_LO:  evt_o.charge = CHG_W'(5);
        PH_LEN_HI:  evt_o.charge = CHG_W'(6);
        PH_PAYLOAD: evt_o.charge = CHG_W'(6) + CHG_W'(got);
        PH_CK_A:    evt_o.charge = CHG_W'(7) + CHG_W'(dlen_q);
        PH_CK_B:    evt_o.charge = CHG_W'(8) + CHG_W'(dlen_q);
        default:    evt_o.charge = CHG_W'(1);
      endcase
    end else begin
      evt_o.bump_noise = item_i.noise;
      if (!item_i.sink_ready) begin
        evt_o.charge = CHG_W'(1);
      end else begin
        unique case (phase_q)
          PH_HUNT1: begin
            if (b == SYNC_FIRST) phase_d = PH_HUNT2;
            else evt_o.charge = CHG_W'(1);
          end
          PH_HUNT2: begin
            if (b == SYNC_SECOND) begin
              phase_d = PH_CLASS;
            end else begin
              phase_d = PH_HUNT1;
              evt_o.charge = CHG_W'(2);
            end
          end
          PH_CLASS: begin
            class_d = b;
            sum_a_d = b;
            sum_b_d = b;
            phase_d = PH_ID;
          end
          PH_ID: begin
            sum_a_d = sa_abs;
            sum_b_d = sb_abs;
            if (class_q == exp_class_i && b == exp_id_i) begin
              phase_d = PH_LEN_LO;
            end else begin
              phase_d = PH_HUNT1;
              evt_o.charge = CHG_W'(4);
            end
          end
          PH_LEN_LO: begin
            dlen_d  = {8'd0, b};
            sum_a_d = sa_abs;
            sum_b_d = sb_abs;
            phase_d = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            dlen_d  = len_full;
            left_d  = len_full;
            sum_a_d = sa_abs;
            sum_b_d = sb_abs;
            if (len_full != exp_length_i) begin
              phase_d = PH_HUNT1;
              evt_o.charge = CHG_W'(6);
            end else if (len_full == 16'd0) begin
              phase_d = PH_CK_A;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            res_o.payload_valid = 1'b1;
            res_o.payload_byte  = b;
            res_o.payload_index = got;
            sum_a_d = sa_abs;
            sum_b_d = sb_abs;
            left_d  = left_q - 16'd1;
            if (left_q == 16'd1) phase_d = PH_CK_A;
          end
          PH_CK_A: begin
            if (b == sum_a_q) begin
              phase_d = PH_CK_B;
            end else begin
              phase_d = PH_HUNT1;
              res_o.frame_bad = 1'b1;
              evt_o.charge = CHG_W'(7) + CHG_W'(dlen_q);
            end
          end
          PH_CK_B: begin
            if (b == sum_b_q) begin
              res_o.frame_good = 1'b1;
              evt_o.bump_good  = 1'b1;
            end else begin
              res_o.frame_bad = 1'b1;
              evt_o.charge = CHG_W'(8) + CHG_W'(dlen_q);
            end
            phase_d = PH_HUNT1;
          end
          default: begin
            evt_o.charge = CHG_W'(1);
            phase_d = PH_HUNT1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      sum_a_q <= '0;
      sum_b_q <= '0;
      class_q <= '0;
      dlen_q  <= '0;
      left_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      class_q <= class_d;
      dlen_q  <= dlen_d;
      left_q  <= left_d;
    end
  end

endmodule

>>> design/ubxfr_counters.sv
// ubxfr_counters: wrapping statistics counters for drops, good frames and
// receiver errors. Depends on ubxfr_pkg; shows the low 32 bits of each.
module ubxfr_counters import ubxfr_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  ubxfr_evt_t    evt_i,
  output ubxfr_totals_t totals_o
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned AW = (CW > CHG_W) ? CW : CHG_W;

  logic [CW-1:0] dropped_q, good_q, parity_q, framing_q, overrun_q, noise_q;
  logic [AW-1:0] dropped_sum;

  assign dropped_sum = AW'(dropped_q) + AW'(evt_i.charge);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dropped_q <= '0;
      good_q    <= '0;
      parity_q  <= '0;
      framing_q <= '0;
      overrun_q <= '0;
      noise_q   <= '0;
    end else if (en_i) begin
      dropped_q <= dropped_sum[CW-1:0];
      good_q    <= good_q + CW'(evt_i.bump_good);
      parity_q  <= parity_q + CW'(evt_i.bump_parity);
      framing_q <= framing_q + CW'(evt_i.bump_framing);
      overrun_q <= overrun_q + CW'(evt_i.bump_overrun);
      noise_q   <= noise_q + CW'(evt_i.bump_noise);
    end
  end

  if (CW >= TOTAL_W) begin : g_wide
    assign totals_o.dropped = dropped_q[TOTAL_W-1:0];
    assign totals_o.good    = good_q[TOTAL_W-1:0];
    assign totals_o.parity  = parity_q[TOTAL_W-1:0];
    assign totals_o.framing = framing_q[TOTAL_W-1:0];
    assign totals_o.overrun = overrun_q[TOTAL_W-1:0];
    assign totals_o.noise   = noise_q[TOTAL_W-1:0];
  end else begin : g_narrow
    assign totals_o.dropped = TOTAL_W'(dropped_q);
    assign totals_o.good    = TOTAL_W'(good_q);
    assign totals_o.parity  = TOTAL_W'(parity_q);
    assign totals_o.framing = TOTAL_W'(framing_q);
    assign totals_o.overrun = TOTAL_W'(overrun_q);
    assign totals_o.noise   = TOTAL_W'(noise_q);
  end

endmodule

>>> design/ubxfr_frame_receiver_top.sv
// ubx_frame_receiver_top: input register, parser, counters and result register.
// Depends on ubxfr_pkg, ubxfr_parser and ubxfr_counters.
//
// Usage:
//   s_axis carries one received serial byte per transaction with its error
//   flags and the sink-ready flag. m_axis returns exactly one result per
//   input byte: payload byte and index, good/bad frame marks and the six
//   running counters as they stand after that byte.
//   cfg_we_i/cfg_idx_i/cfg_data_i write expected class (0), id (1) and
//   payload length (2); other indexes are ignored. Write only while idle.
//   A byte passes through the input register, then through the parser into
//   the result register.
//   Throughput is one byte per cycle while m_axis is not stalled; the parse
//   state and counters update in the single cycle the byte moves into the result register.
//   When the receiver stalls, the result holds and one more byte is taken
//   into the input register if it is empty, then s_axis_tready drops until the result is
//   taken. Reset empties both registers, restarts the sync hunt, zeroes all
//   counters and restores the configuration defaults.
module ubx_frame_receiver_top import ubxfr_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] rx_byte, [8] parity_flag, [9] framing_flag, [10] overrun_flag,
  // [11] noise_flag, [12] sink_ready, [15:13] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] payload_valid, [8:1] payload_byte, [24:9] payload_index,
  // [25] frame_good, [26] frame_bad, [58:27] dropped_total,
  // [90:59] good_total, [122:91] parity_total, [154:123] framing_total,
  // [186:155] overrun_total, [218:187] noise_total, [223:219] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [7:0]  exp_class_q;
  logic [7:0]  exp_id_q;
  logic [15:0] exp_length_q;

  logic          in_valid_q;
  ubxfr_item_t   in_item_q;
  logic          out_valid_q;
  ubxfr_res_t    res_q;
  ubxfr_res_t    res_d;
  ubxfr_evt_t    evt;
  ubxfr_totals_t totals;
  logic          advance;
  logic          proc_en;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign proc_en       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_class_q  <= RST_CLASS;
      exp_id_q     <= RST_ID;
      exp_length_q <= RST_LENGTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLASS:  exp_class_q  <= cfg_data_i[7:0];
        REG_ID:     exp_id_q     <= cfg_data_i[7:0];
        REG_LENGTH: exp_length_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_item_q <= s_axis_tdata[12:0];
    if (proc_en) res_q <= res_d;
  end

  ubxfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (proc_en),
    .item_i       (in_item_q),
    .exp_class_i  (exp_class_q),
    .exp_id_i     (exp_id_q),
    .exp_length_i (exp_length_q),
    .res_o        (res_d),
    .evt_o        (evt)
  );

  ubxfr_counters #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (proc_en),
    .evt_i    (evt),
    .totals_o (totals)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, totals, res_q};

endmodule

>>> design/ubxfr_checker.sv
// ubxfr_checker: port-level checks of the frame receiver over time.
// Depends on ubx_frame_receiver_top ports; bound to it below.
module ubxfr_checker import ubxfr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic        pv, good, bad;
  logic [7:0]  pbyte;
  logic [15:0] pidx;
  logic [31:0] good_total;

  assign pv         = m_axis_tdata[0];
  assign pbyte      = m_axis_tdata[8:1];
  assign pidx       = m_axis_tdata[24:9];
  assign good       = m_axis_tdata[25];
  assign bad        = m_axis_tdata[26];
  assign good_total = m_axis_tdata[90:59];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a downstream stall");

  a_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(good && bad) && !(pv && (good || bad)))
    else $error("conflicting result marks");

  a_idle_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !pv |-> pbyte == 8'd0 && pidx == 16'd0)
    else $error("payload fields set without payload_valid");

  a_good_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && $past(m_axis_tvalid) && $past(m_axis_tready) && $past(rst_ni)
    |-> (good_total == $past(good_total) + 32'd1) == good)
    else $error("good_total out of step with frame_good");

endmodule

bind ubx_frame_receiver_top ubxfr_checker u_ubxfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> sim/tb_ubx_frame_receiver_top.sv
// Testbench for ubx_frame_receiver_top: directed and random serial byte streams,
// scored against an in-bench frame parser model. Depends on ubxfr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_ubx_frame_receiver_top import ubxfr_pkg::*;;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned FULL_FRAME = 32'hFFFF_FFFF;

  typedef enum int unsigned {CK_GOOD, CK_BAD_A, CK_BAD_B} ck_kind_e;

  typedef struct packed {
    ubxfr_totals_t tot;
    ubxfr_res_t    res;
  } rx_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ubx_frame_receiver_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // parser model state
  logic [7:0]    cfg_class = RST_CLASS;
  logic [7:0]    cfg_id = RST_ID;
  logic [15:0]   cfg_length = RST_LENGTH;
  ubxfr_phase_e  phase = PH_HUNT1;
  logic [7:0]    fl_a = '0;
  logic [7:0]    fl_b = '0;
  logic [7:0]    hdr_class = '0;
  logic [15:0]   hdr_length = '0;
  logic [15:0]   remaining = '0;
  logic [31:0]   dropped_cnt = '0;
  logic [31:0]   good_cnt = '0;
  logic [31:0]   parity_cnt = '0;
  logic [31:0]   framing_cnt = '0;
  logic [31:0]   overrun_cnt = '0;
  logic [31:0]   noise_cnt = '0;

  rx_result_t    expected_results[$];
  int unsigned   error_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   flag_rate = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   rx_cycle = 0;
  int unsigned   rx_mode = 0;
  int unsigned   rdy_left = 0;

  task automatic predict_rx_byte(input ubxfr_item_t it);
    rx_result_t  r;
    logic [15:0] seen;
    r = '0;
    seen = hdr_length - remaining;
    if (it.parity) parity_cnt++;
    if (it.framing) framing_cnt++;
    if (it.overrun) begin
      overrun_cnt++;
      case (phase)
        PH_HUNT1:   dropped_cnt += 32'd1;
        PH_HUNT2:   dropped_cnt += 32'd2;
        PH_CLASS:   dropped_cnt += 32'd3;
        PH_ID:      dropped_cnt += 32'd4;
        PH_LEN_LO:  dropped_cnt += 32'd5;
        PH_LEN_HI:  dropped_cnt += 32'd6;
        PH_PAYLOAD: dropped_cnt += 32'd6 + 32'(seen);
        PH_CK_A:    dropped_cnt += 32'd7 + 32'(hdr_length);
        PH_CK_B:    dropped_cnt += 32'd8 + 32'(hdr_length);
        default:    dropped_cnt += 32'd1;
      endcase
      phase = PH_HUNT1;
    end else begin
      if (it.noise) noise_cnt++;
      if (!it.sink_ready) begin
        dropped_cnt += 32'd1;
      end else begin
        case (phase)
          PH_HUNT1: begin
            if (it.rx_byte == SYNC_FIRST) phase = PH_HUNT2;
            else dropped_cnt += 32'd1;
          end
          PH_HUNT2: begin
            if (it.rx_byte == SYNC_SECOND) begin
              phase = PH_CLASS;
            end else begin
              phase = PH_HUNT1;
              dropped_cnt += 32'd2;
            end
          end
          PH_CLASS: begin
            hdr_class = it.rx_byte;
            fl_a = it.rx_byte;
            fl_b = it.rx_byte;
            phase = PH_ID;
          end
          PH_ID: begin
            fl_a = fl_a + it.rx_byte;
            fl_b = fl_b + fl_a;
            if (hdr_class == cfg_class && it.rx_byte == cfg_id) begin
              phase = PH_LEN_LO;
            end else begin
              phase = PH_HUNT1;
              dropped_cnt += 32'd4;
            end
          end
          PH_LEN_LO: begin
            hdr_length = {8'h00, it.rx_byte};
            fl_a = fl_a + it.rx_byte;
            fl_b = fl_b + fl_a;
            phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            hdr_length[15:8] = it.rx_byte;
            remaining = hdr_length;
            fl_a = fl_a + it.rx_byte;
            fl_b = fl_b + fl_a;
            if (hdr_length != cfg_length) begin
              phase = PH_HUNT1;
              dropped_cnt += 32'd6;
            end else if (hdr_length == 16'd0) begin
              phase = PH_CK_A;
            end else begin
              phase = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            r.res.payload_valid = 1'b1;
            r.res.payload_byte = it.rx_byte;
            r.res.payload_index = seen;
            fl_a = fl_a + it.rx_byte;
            fl_b = fl_b + fl_a;
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) phase = PH_CK_A;
          end
          PH_CK_A: begin
            if (it.rx_byte == fl_a) begin
              phase = PH_CK_B;
            end else begin
              phase = PH_HUNT1;
              r.res.frame_bad = 1'b1;
              dropped_cnt += 32'd7 + 32'(hdr_length);
            end
          end
          PH_CK_B: begin
            if (it.rx_byte == fl_b) begin
              r.res.frame_good = 1'b1;
              good_cnt++;
            end else begin
              r.res.frame_bad = 1'b1;
              dropped_cnt += 32'd8 + 32'(hdr_length);
            end
            phase = PH_HUNT1;
          end
          default: begin
            dropped_cnt += 32'd1;
            phase = PH_HUNT1;
          end
        endcase
      end
    end
    r.tot.dropped = dropped_cnt;
    r.tot.good = good_cnt;
    r.tot.parity = parity_cnt;
    r.tot.framing = framing_cnt;
    r.tot.overrun = overrun_cnt;
    r.tot.noise = noise_cnt;
    expected_results.push_back(r);
  endtask

  function automatic ubxfr_item_t mk_item(input logic [7:0] b, input logic par,
                                          input logic frm, input logic ovr,
                                          input logic nse, input logic snk);
    ubxfr_item_t it;
    it.rx_byte = b;
    it.parity = par;
    it.framing = frm;
    it.overrun = ovr;
    it.noise = nse;
    it.sink_ready = snk;
    return it;
  endfunction

  // called at a rising edge; returns at the edge that completed the transaction, or after a random idle gap
  task automatic send_item(input ubxfr_item_t it);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(S_TDATA_W - 13){1'b0}}, it};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rx_byte(it);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(mk_item(b, $urandom_range(0, 999) < flag_rate,
                      $urandom_range(0, 999) < flag_rate,
                      $urandom_range(0, 1999) < flag_rate,
                      $urandom_range(0, 999) < flag_rate,
                      $urandom_range(0, 999) >= flag_rate));
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input int unsigned npay,
                            input ck_kind_e ck, input int unsigned keep);
    logic [7:0]  frame_q[$];
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  v;
    int unsigned k;
    frame_q = '{SYNC_FIRST, SYNC_SECOND, cls, id, len[7:0], len[15:8]};
    a = '0;
    b = '0;
    for (k = 2; k < 6; k++) begin
      a = a + frame_q[k];
      b = b + a;
    end
    for (k = 0; k < npay; k++) begin
      v = 8'($urandom);
      frame_q.push_back(v);
      a = a + v;
      b = b + a;
    end
    if (ck == CK_BAD_A) a = a ^ 8'($urandom_range(1, 255));
    if (ck == CK_BAD_B) b = b ^ 8'($urandom_range(1, 255));
    frame_q.push_back(a);
    frame_q.push_back(b);
    for (k = 0; k < frame_q.size() && k < keep; k++) send_data(frame_q[k]);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_CLASS:  cfg_class = data[7:0];
      REG_ID:     cfg_id = data[7:0];
      REG_LENGTH: cfg_length = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] cls, input logic [7:0] id,
                           input logic [15:0] len);
    wait_idle();
    write_reg(REG_CLASS, {8'h00, cls});
    write_reg(REG_ID, {8'h00, id});
    write_reg(REG_LENGTH, len);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_error_flags();
    send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk_item(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk_item(SYNC_FIRST, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
    send_item(mk_item(SYNC_SECOND, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(mk_item(8'h5A, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_item(mk_item(8'hA5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(mk_item(SYNC_FIRST, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk_item(SYNC_FIRST, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_frame_rules();
    flag_rate = 0;
    configure(8'hFF, 8'h00, 16'd1);
    send_frame(8'hFF, 8'h00, 16'd1, 1, CK_GOOD, FULL_FRAME);
    send_frame(8'hFF, 8'h01, 16'd1, 1, CK_GOOD, 4);
    configure(8'h00, 8'hFF, 16'd0);
    send_frame(8'h00, 8'hFF, 16'd0, 0, CK_GOOD, FULL_FRAME);
    send_frame(8'h00, 8'hFF, 16'd0, 0, CK_BAD_A, FULL_FRAME);
  endtask

  // maximum declared length: header and part of the payload, then an overrun, then a frame of mismatched length
  task automatic test_max_length();
    flag_rate = 0;
    configure(8'($urandom), 8'($urandom), 16'hFFFF);
    send_frame(cfg_class, cfg_id, 16'hFFFF, 40, CK_GOOD, 46);
    send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_frame(cfg_class, cfg_id, 16'hFFFE, 4, CK_GOOD, FULL_FRAME);
  endtask

  task automatic test_random_frames();
    int unsigned n;
    int unsigned k;
    int unsigned sel;
    logic [15:0] len;
    flag_rate = 0;
    send_frame(RST_CLASS, RST_ID, RST_LENGTH, RST_LENGTH, CK_GOOD, FULL_FRAME);
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: configure(8'h00, 8'h00, 16'd1);
        1: configure(8'hFF, 8'hFF, 16'd2);
        2: configure(8'($urandom), 8'($urandom), 16'($urandom_range(1, 4)));
        default: configure(8'($urandom), 8'($urandom), 16'($urandom_range(1, 12)));
      endcase
      flag_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      n = $urandom_range(3, 8);
      for (k = 0; k < n; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          send_frame(cfg_class, cfg_id, cfg_length, cfg_length, CK_GOOD, FULL_FRAME);
        end else if (sel < 70) begin
          send_frame(cfg_class, cfg_id, cfg_length, cfg_length,
                     ($urandom_range(0, 1) != 0) ? CK_BAD_A : CK_BAD_B, FULL_FRAME);
        end else if (sel < 80) begin
          len = cfg_length ^ (16'd1 << $urandom_range(0, 15));
          case ($urandom_range(0, 2))
            0: send_frame(cfg_class ^ 8'($urandom_range(1, 255)), cfg_id, cfg_length,
                          cfg_length, CK_GOOD, FULL_FRAME);
            1: send_frame(cfg_class, cfg_id ^ 8'($urandom_range(1, 255)), cfg_length,
                          cfg_length, CK_GOOD, FULL_FRAME);
            default: send_frame(cfg_class, cfg_id, len, cfg_length, CK_GOOD, FULL_FRAME);
          endcase
        end else if (sel < 90) begin
          send_frame(cfg_class, cfg_id, cfg_length, cfg_length, CK_GOOD,
                     $urandom_range(1, 8 + cfg_length));
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_data(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
          end
        end
      end
    end
  endtask

  // receiver backpressure: m_axis_tready follows a randomly redrawn mode (held high, or toggled)
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
    if (rdy_left != 0) begin
      rdy_left--;
    end else if (rx_mode == 0) begin
      m_axis_tready <= 1'b1;
      rdy_left = 31;
    end else if (rx_mode == 1) begin
      m_axis_tready <= ~m_axis_tready;
      rdy_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= ~m_axis_tready;
      rdy_left = m_axis_tready ? $urandom_range(2, 12) : $urandom_range(0, 5);
    end
  end

  function automatic void field_check(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    rx_result_t    want;
    ubxfr_res_t    got_res;
    ubxfr_totals_t got_tot;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transaction with no expectation, actual %0h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        got_res = m_axis_tdata[26:0];
        got_tot = m_axis_tdata[218:27];
        field_check("payload_valid", 32'(want.res.payload_valid),
                    32'(got_res.payload_valid));
        field_check("payload_byte", 32'(want.res.payload_byte), 32'(got_res.payload_byte));
        field_check("payload_index", 32'(want.res.payload_index),
                    32'(got_res.payload_index));
        field_check("frame_good", 32'(want.res.frame_good), 32'(got_res.frame_good));
        field_check("frame_bad", 32'(want.res.frame_bad), 32'(got_res.frame_bad));
        field_check("dropped_total", want.tot.dropped, got_tot.dropped);
        field_check("good_total", want.tot.good, got_tot.good);
        field_check("parity_total", want.tot.parity, got_tot.parity);
        field_check("framing_total", want.tot.framing, got_tot.framing);
        field_check("overrun_total", want.tot.overrun, got_tot.overrun);
        field_check("noise_total", want.tot.noise, got_tot.noise);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_error_flags();
    test_frame_rules();
    test_random_frames();
    test_max_length();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
design/ubxfr_pkg.sv
design/ubxfr_parser.sv
design/ubxfr_counters.sv
design/ubxfr_frame_receiver_top.sv
design/ubxfr_checker.sv
sim/tb_ubx_frame_receiver_top.sv
